### rtl/ulpa_pkg.sv
`default_nettype none

package ulpa_pkg;

    // Default number of fraction bits in the bits-of-error format.
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Width of the bits-of-error fields and their saturation value.
    localparam int unsigned ERR_W = 23;
    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // IEEE-754 double constants.
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] EXP_ALL  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NAN_ULPS = 64'hFFFF_FFFF_FFFF_FFFE;

    typedef struct packed {
        logic [63:0] shadow_bits;
        logic [63:0] computed_bits;
    } t_in_item;

    typedef struct packed {
        logic [ERR_W-1:0] bits_error;
        logic [63:0]      ulps_error;
        logic [ERR_W-1:0] max_error_out;
        logic [63:0]      total_error_out;
        logic [63:0]      eval_count_out;
    } t_out_item;

    // Side information that travels with an item down the pipeline.
    typedef struct packed {
        logic [63:0] ulps;
        logic        nan;
        logic        dis;
        logic [5:0]  e;
    } t_carry;

endpackage

`default_nettype wire

### rtl/ulp_error_aggregator_unit.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ---------------------------------
// in        sink       i_in_valid / o_in_ready    i_in_data  (ulpa_pkg::t_in_item)
// out       source     o_out_valid / i_out_ready  o_out_data (ulpa_pkg::t_out_item)
// cfg       sink       i_cfg_we (no wait)         i_cfg_wdata (disable_shadow)
//
// One beat is accepted per cycle and one result beat leaves per cycle when the
// sink keeps i_out_ready high. The depth of the pipeline is set by the squaring
// chain of the log2 unit, where every fraction bit takes one partial-product
// stage and one add stage.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the maximum,
// total and count, and clears disable_shadow.
// A stalled output only holds back the stages behind it that are full, so
// empty slots in the pipeline keep filling while a result waits.

module ulp_error_aggregator_unit #(
    parameter int unsigned FRAC_BITS = ulpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ulpa_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output ulpa_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_wdata
);

    import ulpa_pkg::*;

    // Stage map:
    //   0            input register
    //   1            -0 fold, NaN test, ordered keys
    //   2            absolute key difference (ULP distance)
    //   3            n = ulps + 1, leading-zero shifts by 32, 16, 8
    //   4            leading-zero shifts by 4, 2, 1; exponent and mantissa
    //   5 + 2i       partial products of the i-th mantissa square
    //   6 + 2i       sum of partial products, renormalize, emit fraction bit
    //   5 + 2F       bits of error, NaN override, saturation, disable
    //   6 + 2F       aggregates and output register
    localparam int unsigned ST_M0  = 5;
    localparam int unsigned ST_SF  = 5 + 2 * FRAC_BITS;
    localparam int unsigned ST_OUT = 6 + 2 * FRAC_BITS;
    localparam int unsigned NST    = 7 + 2 * FRAC_BITS;

    // The log2 value holds a 6-bit exponent, one spare bit for the NaN case
    // of exactly 64.0, and the fraction.
    localparam int unsigned W_LG  = 7 + FRAC_BITS;
    localparam int unsigned W_CMP = (W_LG > ERR_W) ? W_LG : ERR_W;

    // Valid bits and per-stage load enables. A stage loads when it is empty
    // or when the stage after it loads in the same cycle.
    logic [NST-1:0] r_v;
    logic [NST-1:0] ld;

    always_comb begin
        ld[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
    end

    assign o_in_ready  = ld[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ld[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Configuration register.
    logic r_dis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dis <= 1'b0;
        end else if (i_cfg_we) begin
            r_dis <= i_cfg_wdata;
        end
    end

    // Stage 0: input register. The disable flag is sampled with the beat.
    t_in_item r_s0;
    logic     r_s0_dis;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0     <= i_in_data;
            r_s0_dis <= r_dis;
        end
    end

    // Stage 1: negative zero folds to positive zero, then each pattern maps
    // to an ordered key, 2^63 + magnitude or 2^63 - magnitude by its sign.
    logic [63:0] x_fold;
    logic [63:0] y_fold;
    logic [63:0] n_s1_kx;
    logic [63:0] n_s1_ky;
    logic        n_s1_nan;
    logic [63:0] r_s1_kx;
    logic [63:0] r_s1_ky;
    logic        r_s1_nan;
    logic        r_s1_dis;

    always_comb begin
        x_fold   = (r_s0.shadow_bits == SIGN_BIT) ? 64'd0 : r_s0.shadow_bits;
        y_fold   = (r_s0.computed_bits == SIGN_BIT) ? 64'd0 : r_s0.computed_bits;
        n_s1_nan = ((x_fold & MAG_MASK) > EXP_ALL) || ((y_fold & MAG_MASK) > EXP_ALL);
        n_s1_kx  = x_fold[63] ? (SIGN_BIT - (x_fold & MAG_MASK))
                              : (SIGN_BIT | (x_fold & MAG_MASK));
        n_s1_ky  = y_fold[63] ? (SIGN_BIT - (y_fold & MAG_MASK))
                              : (SIGN_BIT | (y_fold & MAG_MASK));
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s1_kx  <= n_s1_kx;
            r_s1_ky  <= n_s1_ky;
            r_s1_nan <= n_s1_nan;
            r_s1_dis <= r_s0_dis;
        end
    end

    // Stage 2: both differences are formed and the borrow of one picks the
    // nonnegative one.
    logic [64:0] d_xy;
    logic [64:0] d_yx;
    t_carry      n_s2;
    t_carry      r_s2;

    always_comb begin
        d_xy      = {1'b0, r_s1_kx} - {1'b0, r_s1_ky};
        d_yx      = {1'b0, r_s1_ky} - {1'b0, r_s1_kx};
        n_s2.ulps = d_xy[64] ? d_yx[63:0] : d_xy[63:0];
        n_s2.nan  = r_s1_nan;
        n_s2.dis  = r_s1_dis;
        n_s2.e    = 6'd0;
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 3: n = ulps + 1 and the coarse half of the normalizing shift.
    // In the NaN case n is never used, so its wrap does not matter.
    logic [63:0] n_s3_m;
    logic [5:0]  n_s3_c;
    logic [63:0] r_s3_m;
    logic [5:0]  r_s3_c;
    t_carry      r_s3;

    always_comb begin
        n_s3_m = r_s2.ulps + 64'd1;
        n_s3_c = 6'd0;
        if (n_s3_m[63:32] == 32'd0) begin
            n_s3_m    = {n_s3_m[31:0], 32'd0};
            n_s3_c[5] = 1'b1;
        end
        if (n_s3_m[63:48] == 16'd0) begin
            n_s3_m    = {n_s3_m[47:0], 16'd0};
            n_s3_c[4] = 1'b1;
        end
        if (n_s3_m[63:56] == 8'd0) begin
            n_s3_m    = {n_s3_m[55:0], 8'd0};
            n_s3_c[3] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s3_m <= n_s3_m;
            r_s3_c <= n_s3_c;
            r_s3   <= r_s2;
        end
    end

    // Stage 4: the fine half of the shift. The leading one now sits in bit 63,
    // so the mantissa reads as Q1.63 in [1, 2), and the exponent is 63 minus
    // the shift count, which is its bitwise complement.
    logic [63:0] n_s4_m;
    logic [5:0]  n_s4_c;
    t_carry      n_s4;
    logic [63:0] r_s4_m;
    t_carry      r_s4;

    always_comb begin
        n_s4_m = r_s3_m;
        n_s4_c = r_s3_c;
        if (n_s4_m[63:60] == 4'd0) begin
            n_s4_m    = {n_s4_m[59:0], 4'd0};
            n_s4_c[2] = 1'b1;
        end
        if (n_s4_m[63:62] == 2'd0) begin
            n_s4_m    = {n_s4_m[61:0], 2'd0};
            n_s4_c[1] = 1'b1;
        end
        if (!n_s4_m[63]) begin
            n_s4_m    = {n_s4_m[62:0], 1'b0};
            n_s4_c[0] = 1'b1;
        end
        n_s4   = r_s3;
        n_s4.e = ~n_s4_c;
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s4_m <= n_s4_m;
            r_s4   <= n_s4;
        end
    end

    // Fraction bits by repeated squaring. Each square of the Q1.63 mantissa is
    // exact as a 128-bit value built from three 32x32 products; its top part
    // is kept truncated, halved first when the square has reached 2.
    logic [63:0]          r_p0 [FRAC_BITS];
    logic [63:0]          r_p1 [FRAC_BITS];
    logic [63:0]          r_p3 [FRAC_BITS];
    t_carry               r_cm [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fm [FRAC_BITS];
    logic [63:0]          r_ma [FRAC_BITS];
    t_carry               r_ca [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fa [FRAC_BITS];

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
        logic [63:0]          m_in;
        t_carry               c_in;
        logic [FRAC_BITS-1:0] f_in;
        logic [34:0]          mid;
        logic [63:0]          hi;
        logic                 lo_top;
        logic [63:0]          n_m;

        if (i == 0) begin : g_first
            assign m_in = r_s4_m;
            assign c_in = r_s4;
            assign f_in = '0;
        end else begin : g_next
            assign m_in = r_ma[i-1];
            assign c_in = r_ca[i-1];
            assign f_in = r_fa[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (ld[ST_M0 + 2 * i]) begin
                r_p0[i] <= 64'(m_in[31:0] * m_in[31:0]);
                r_p1[i] <= 64'(m_in[31:0] * m_in[63:32]);
                r_p3[i] <= 64'(m_in[63:32] * m_in[63:32]);
                r_cm[i] <= c_in;
                r_fm[i] <= f_in;
            end
        end

        always_comb begin
            mid    = {3'd0, r_p0[i][63:32]} + {2'd0, r_p1[i][31:0], 1'b0};
            hi     = r_p3[i] + {r_p1[i][63:32], 1'b0} + {61'd0, mid[34:32]};
            lo_top = mid[31];
            n_m    = hi[63] ? hi : {hi[62:0], lo_top};
        end

        always_ff @(posedge i_clk) begin
            if (ld[ST_M0 + 2 * i + 1]) begin
                r_ma[i] <= n_m;
                r_ca[i] <= r_cm[i];
                r_fa[i] <= {r_fm[i][FRAC_BITS-2:0], hi[63]};
            end
        end
    end

    // Final log2 stage: assemble exponent and fraction, apply the NaN value
    // of exactly 64.0, saturate to the field width, and zero when disabled.
    logic [W_LG-1:0]  lg;
    logic [W_CMP-1:0] lg_ext;
    logic [ERR_W-1:0] n_sf_bits;
    logic [63:0]      n_sf_ulps;
    logic [ERR_W-1:0] r_sf_bits;
    logic [63:0]      r_sf_ulps;
    logic             r_sf_dis;

    always_comb begin
        lg        = r_ca[FRAC_BITS-1].nan ? W_LG'(64) << FRAC_BITS
                                          : {1'b0, r_ca[FRAC_BITS-1].e, r_fa[FRAC_BITS-1]};
        lg_ext    = W_CMP'(lg);
        n_sf_bits = (lg_ext > W_CMP'(ERR_MAX)) ? ERR_MAX : lg_ext[ERR_W-1:0];
        n_sf_ulps = r_ca[FRAC_BITS-1].nan ? NAN_ULPS : r_ca[FRAC_BITS-1].ulps;
        if (r_ca[FRAC_BITS-1].dis) begin
            n_sf_bits = '0;
            n_sf_ulps = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_SF]) begin
            r_sf_bits <= n_sf_bits;
            r_sf_ulps <= n_sf_ulps;
            r_sf_dis  <= r_ca[FRAC_BITS-1].dis;
        end
    end

    // Aggregates. They move only when an enabled beat enters the output
    // register, so each beat is counted exactly once.
    logic [ERR_W-1:0] r_max;
    logic [63:0]      r_total;
    logic [63:0]      r_count;
    logic [ERR_W-1:0] n_max;
    logic [63:0]      n_total;
    logic [63:0]      n_count;
    logic [64:0]      total_sum;
    logic             agg_upd;
    t_out_item        r_out;

    always_comb begin
        agg_upd   = ld[ST_OUT] && r_v[ST_SF] && !r_sf_dis;
        total_sum = {1'b0, r_total} + 65'(r_sf_bits);
        n_max     = r_max;
        n_total   = r_total;
        n_count   = r_count;
        if (!r_sf_dis) begin
            n_max   = (r_sf_bits > r_max) ? r_sf_bits : r_max;
            n_total = total_sum[64] ? '1 : total_sum[63:0];
            n_count = (r_count == '1) ? r_count : r_count + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_total <= '0;
            r_count <= '0;
        end else if (agg_upd) begin
            r_max   <= n_max;
            r_total <= n_total;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_OUT]) begin
            r_out.bits_error      <= r_sf_bits;
            r_out.ulps_error      <= r_sf_ulps;
            r_out.max_error_out   <= n_max;
            r_out.total_error_out <= n_total;
            r_out.eval_count_out  <= n_count;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

### rtl/ulpa_checker.sv
`default_nettype none

module ulpa_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire ulpa_pkg::t_out_item o_out_data
);

    import ulpa_pkg::*;

    // Aggregates of the last result beat taken.
    logic [ERR_W-1:0] r_last_max;
    logic [63:0]      r_last_total;
    logic [63:0]      r_last_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_max   <= '0;
            r_last_total <= '0;
            r_last_count <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_max   <= o_out_data.max_error_out;
            r_last_total <= o_out_data.total_error_out;
            r_last_count <= o_out_data.eval_count_out;
        end
    end

    // A result beat that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // The running maximum always covers the beat it is reported with.
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.bits_error <= o_out_data.max_error_out)
        else $error("bits_error above reported maximum");

    // Equal values, or a disabled beat, carry no bit error.
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ulps_error == 64'd0 |-> o_out_data.bits_error == '0)
        else $error("nonzero bit error at zero ULP distance");

    // Aggregates never move backward from one beat to the next.
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.max_error_out >= r_last_max
                     && o_out_data.total_error_out >= r_last_total
                     && o_out_data.eval_count_out >= r_last_count)
        else $error("aggregate decreased between result beats");

endmodule

bind ulp_error_aggregator_unit ulpa_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
